[rtl/core/rvc_pkg.sv]
package rvc_pkg;

  // Supplies and table layout
  localparam int NUM_SUPPLIES = 14;
  localparam int SUP_W        = 4;

  // Command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_DISABLED = 2'd2
  } rvc_status_e;

  // Reciprocals for division by a step: q = (x * RCP) >> RCP_SHIFT, exact for x < 4096
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = 21;
  localparam logic [RCP_W-1:0] RCP_0   = '0;
  localparam logic [RCP_W-1:0] RCP_10  = RCP_W'(((1 << RCP_SHIFT) + 10 - 1) / 10);
  localparam logic [RCP_W-1:0] RCP_20  = RCP_W'(((1 << RCP_SHIFT) + 20 - 1) / 20);
  localparam logic [RCP_W-1:0] RCP_50  = RCP_W'(((1 << RCP_SHIFT) + 50 - 1) / 50);
  localparam logic [RCP_W-1:0] RCP_100 = RCP_W'(((1 << RCP_SHIFT) + 100 - 1) / 100);
  localparam logic [RCP_W-1:0] RCP_560 = RCP_W'(((1 << RCP_SHIFT) + 560 - 1) / 560);

  // One supply's segment row; a step of zero marks an absent segment
  typedef struct packed {
    logic [6:0]       mask;
    logic [11:0]      min1;
    logic [11:0]      max1;
    logic [9:0]       step1;
    logic [RCP_W-1:0] rcp1;
    logic [6:0]       n1;
    logic [11:0]      min2;
    logic [11:0]      max2;
    logic [9:0]       step2;
    logic [RCP_W-1:0] rcp2;
    logic [6:0]       n2;
    logic [11:0]      min3;
    logic [11:0]      max3;
    logic [9:0]       step3;
    logic [RCP_W-1:0] rcp3;
  } rvc_row_t;

  // Order: mask, min1, max1, step1, rcp1, n1, min2, max2, step2, rcp2, n2,
  //        min3, max3, step3, rcp3
  localparam rvc_row_t ROW_TABLE [NUM_SUPPLIES] = '{
    '{7'h1f, 12'd1500, 12'd3400, 10'd100, RCP_100, 7'((3400 - 1500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h7f, 12'd500, 12'd1200, 10'd10, RCP_10, 7'((1200 - 500) / 10),
      12'd1220, 12'd1540, 10'd20, RCP_20, 7'((1540 - 1220) / 20),
      12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h7f, 12'd500, 12'd1200, 10'd10, RCP_10, 7'((1200 - 500) / 10),
      12'd1220, 12'd1540, 10'd20, RCP_20, 7'((1540 - 1220) / 20),
      12'd1600, 12'd3400, 10'd100, RCP_100},
    '{7'h7f, 12'd500, 12'd1200, 10'd10, RCP_10, 7'((1200 - 500) / 10),
      12'd1220, 12'd1840, 10'd20, RCP_20, 7'((1840 - 1220) / 20),
      12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd1400, 12'd3700, 10'd100, RCP_100, 7'((3700 - 1400) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd3500, 10'd100, RCP_100, 7'((3500 - 500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd3500, 10'd100, RCP_100, 7'((3500 - 500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd3500, 10'd100, RCP_100, 7'((3500 - 500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd3500, 10'd100, RCP_100, 7'((3500 - 500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd3500, 10'd100, RCP_100, 7'((3500 - 500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd3500, 10'd100, RCP_100, 7'((3500 - 500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd3400, 10'd100, RCP_100, 7'((3400 - 500) / 100),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd1400, 10'd560, RCP_560, 7'((1400 - 500) / 560),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0},
    '{7'h3f, 12'd500, 12'd1400, 10'd50, RCP_50, 7'((1400 - 500) / 50),
      12'd0, 12'd0, 10'd0, RCP_0, 7'd0, 12'd0, 12'd0, 10'd0, RCP_0}
  };

  localparam int PROD_W = 12 + RCP_W;

  // Beat after segment selection: multiplier operands plus what finishing needs
  typedef struct packed {
    logic              valid;
    logic              dec;
    rvc_status_e       status;
    logic              write;
    logic              chk;
    logic [6:0]        mask;
    logic [11:0]       offset;
    logic [11:0]       limit;
    logic [11:0]       mul_a;
    logic [RCP_W-1:0]  mul_b;
  } rvc_op_t;

  // Beat after the multiplier
  typedef struct packed {
    logic              valid;
    logic              dec;
    rvc_status_e       status;
    logic              write;
    logic              chk;
    logic [6:0]        mask;
    logic [11:0]       offset;
    logic [11:0]       limit;
    logic [PROD_W-1:0] prod;
  } rvc_prod_t;

endpackage

[rtl/core/rvc_front.sv]
module rvc_front
  import rvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             in_cmd,
  input  logic [SUP_W-1:0] in_supply,
  input  logic [11:0]      in_voltage_mv,
  input  logic [6:0]       in_code_in,
  input  logic             in_enable_in,
  output rvc_op_t          op
);

  rvc_op_t  op_r;
  rvc_op_t  op_nxt;
  rvc_row_t row;
  logic     known;
  logic     seg1_hit;
  logic     seg2_hit;
  logic     seg3_hit;
  logic [6:0] c;
  logic [6:0] c2;
  logic [6:0] c3;

  // Look up the supply's row; unknown supplies are rejected below
  assign known = int'(in_supply) < NUM_SUPPLIES;
  assign row   = known ? ROW_TABLE[in_supply] : ROW_TABLE[0];

  // Encode segment hits
  assign seg1_hit = (in_voltage_mv >= row.min1) && (in_voltage_mv <= row.max1);
  assign seg2_hit = (row.step2 != '0) && (in_voltage_mv >= row.min2)
                    && (in_voltage_mv <= row.max2);
  assign seg3_hit = (row.step2 != '0) && (row.step3 != '0)
                    && (in_voltage_mv >= row.min3) && (in_voltage_mv <= row.max3);

  // Decode code positions within segments two and three
  assign c  = in_code_in & row.mask;
  assign c2 = c - row.n1;
  assign c3 = c2 - row.n2 - 7'd2;

  // Pick the segment and set up the multiplier operands
  always_comb begin
    op_nxt        = '0;
    op_nxt.valid  = accept;
    op_nxt.dec    = (in_cmd == CMD_DECODE);
    op_nxt.status = ST_OK;
    op_nxt.mask   = row.mask;
    if (!known) begin
      op_nxt.status = ST_RANGE;
    end else if (in_cmd == CMD_ENCODE) begin
      priority if (in_voltage_mv == '0) begin
        op_nxt.status = ST_OK;
      end else if (seg1_hit) begin
        op_nxt.write  = 1'b1;
        op_nxt.mul_a  = in_voltage_mv - row.min1;
        op_nxt.mul_b  = row.rcp1;
        op_nxt.offset = '0;
      end else if (seg2_hit) begin
        op_nxt.write  = 1'b1;
        op_nxt.mul_a  = in_voltage_mv - row.min2;
        op_nxt.mul_b  = row.rcp2;
        op_nxt.offset = {5'd0, 7'(row.n1 + 7'd1)};
      end else if (seg3_hit) begin
        op_nxt.write  = 1'b1;
        op_nxt.mul_a  = in_voltage_mv - row.min3;
        op_nxt.mul_b  = row.rcp3;
        op_nxt.offset = {5'd0, 7'(row.n1 + row.n2 + 7'd2)};
      end else begin
        op_nxt.status = ST_RANGE;
      end
    end else begin
      priority if (!in_enable_in) begin
        op_nxt.status = ST_DISABLED;
      end else if (c <= row.n1) begin
        op_nxt.mul_a  = {5'd0, c};
        op_nxt.mul_b  = {{(RCP_W-10){1'b0}}, row.step1};
        op_nxt.offset = row.min1;
      end else if (row.step2 == '0) begin
        op_nxt.status = ST_RANGE;
      end else if ({1'b0, c2} > ({1'b0, row.n2} + 8'd1)) begin
        if (row.step3 == '0) begin
          op_nxt.status = ST_RANGE;
        end else begin
          op_nxt.chk    = 1'b1;
          op_nxt.mul_a  = {5'd0, c3};
          op_nxt.mul_b  = {{(RCP_W-10){1'b0}}, row.step3};
          op_nxt.offset = row.min3;
          op_nxt.limit  = row.max3;
        end
      end else begin
        op_nxt.mul_a  = {5'd0, 7'(c2 - 7'd1)};
        op_nxt.mul_b  = {{(RCP_W-10){1'b0}}, row.step2};
        op_nxt.offset = row.min2;
      end
    end
  end

  // Stage register; only the valid bit is cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r.valid <= 1'b0;
    end else begin
      op_r <= op_nxt;
    end
  end

  assign op = op_r;

endmodule

[rtl/core/rvc_mul.sv]
module rvc_mul
  import rvc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rvc_op_t   op,
  output rvc_prod_t pr
);

  rvc_prod_t pr_r;
  rvc_prod_t pr_nxt;

  // Shared multiplier: quotient estimate for encode, step offset for decode
  always_comb begin
    pr_nxt.valid  = op.valid;
    pr_nxt.dec    = op.dec;
    pr_nxt.status = op.status;
    pr_nxt.write  = op.write;
    pr_nxt.chk    = op.chk;
    pr_nxt.mask   = op.mask;
    pr_nxt.offset = op.offset;
    pr_nxt.limit  = op.limit;
    pr_nxt.prod   = PROD_W'(op.mul_a) * PROD_W'(op.mul_b);
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_r.valid <= 1'b0;
    end else begin
      pr_r <= pr_nxt;
    end
  end

  assign pr = pr_r;

endmodule

[rtl/core/rvc_back.sv]
module rvc_back
  import rvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rvc_prod_t   pr,
  output logic        out_valid,
  output logic [6:0]  out_code_out,
  output logic        out_code_write,
  output logic        out_enable_out,
  output logic [11:0] out_voltage_out,
  output logic [1:0]  out_status
);

  logic        valid_r;
  logic [6:0]  code_r;
  logic        write_r;
  logic        enable_r;
  logic [11:0] voltage_r;
  rvc_status_e status_r;

  logic [6:0]  code_nxt;
  logic        write_nxt;
  logic        enable_nxt;
  logic [11:0] voltage_nxt;
  rvc_status_e status_nxt;
  logic [17:0] val;
  logic [6:0]  code_sum;

  // Finish: add the segment base or minimum to the product
  assign code_sum = pr.offset[6:0] + pr.prod[RCP_SHIFT +: 7];
  assign val      = {6'd0, pr.offset} + pr.prod[17:0];

  always_comb begin
    code_nxt    = '0;
    write_nxt   = 1'b0;
    enable_nxt  = 1'b0;
    voltage_nxt = '0;
    status_nxt  = pr.status;
    if (!pr.dec) begin
      if (pr.write) begin
        code_nxt   = code_sum & pr.mask;
        write_nxt  = 1'b1;
        enable_nxt = 1'b1;
      end
    end else if (pr.status == ST_OK) begin
      if (pr.chk && (val > {6'd0, pr.limit})) begin
        status_nxt = ST_RANGE;
      end else begin
        voltage_nxt = val[11:0];
      end
    end
  end

  // Output register: strobe for one cycle per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pr.valid;
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    write_r   <= write_nxt;
    enable_r  <= enable_nxt;
    voltage_r <= voltage_nxt;
    status_r  <= status_nxt;
  end

  assign out_valid       = valid_r;
  assign out_code_out    = code_r;
  assign out_code_write  = write_r;
  assign out_enable_out  = enable_r;
  assign out_voltage_out = voltage_r;
  assign out_status      = status_r;

endmodule

[rtl/core/regulator_voltage_code_codec_unit.sv]
// Regulator voltage code converter, 14 supplies, piecewise linear segments.
// Input: pulse start with in_cmd, in_supply, in_voltage_mv, in_code_in and
// in_enable_in; a command is taken at a clock edge where start is high and
// busy is low. busy is always low: a command may be issued every cycle.
// Encode (in_cmd 0) turns a millivolt target into a register code plus an
// enable bit; decode (in_cmd 1) turns a masked code back into millivolts.
// Output: out_valid is high for exactly one cycle per command, with
// out_code_out, out_code_write, out_enable_out, out_voltage_out, out_status.
// Results come back in command order.
// Throughput is one command per cycle. The stages are segment select, one
// shared 12x21 multiplier (reciprocal divide for encode, step scaling for
// decode), and the final add and range check feeding the output register.
// The receiver cannot hold results off; every result is shown once.
// Reset (rst_n low, synchronous) clears all valid bits and drops any
// commands in flight; there is no other state.
module regulator_voltage_code_codec_unit
  import rvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_cmd,
  input  logic [SUP_W-1:0] in_supply,
  input  logic [11:0]      in_voltage_mv,
  input  logic [6:0]       in_code_in,
  input  logic             in_enable_in,
  output logic             out_valid,
  output logic [6:0]       out_code_out,
  output logic             out_code_write,
  output logic             out_enable_out,
  output logic [11:0]      out_voltage_out,
  output logic [1:0]       out_status
);

  rvc_op_t   op;
  rvc_prod_t pr;
  logic      accept;

  // Pipeline always advances, so never push back
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rvc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_cmd        (in_cmd),
    .in_supply     (in_supply),
    .in_voltage_mv (in_voltage_mv),
    .in_code_in    (in_code_in),
    .in_enable_in  (in_enable_in),
    .op            (op)
  );

  rvc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .pr    (pr)
  );

  rvc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pr              (pr),
    .out_valid       (out_valid),
    .out_code_out    (out_code_out),
    .out_code_write  (out_code_write),
    .out_enable_out  (out_enable_out),
    .out_voltage_out (out_voltage_out),
    .out_status      (out_status)
  );

endmodule

[tb/tb_regulator_voltage_code_codec_unit.sv]
module tb_regulator_voltage_code_codec_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rvc_pkg::*;

  // One supply's segments in millivolts; a step of zero marks an absent segment
  typedef struct {
    int unsigned mask;
    int unsigned min1, max1, step1;
    int unsigned min2, max2, step2;
    int unsigned min3, max3, step3;
  } supply_segs_t;

  // One result beat as the block presents it
  typedef struct packed {
    logic [6:0]  code;
    logic        write;
    logic        enable;
    logic [11:0] voltage;
    rvc_status_e status;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [3:0]  in_supply;
  logic [11:0] in_voltage_mv;
  logic [6:0]  in_code_in;
  logic        in_enable_in;
  logic        out_valid;
  logic [6:0]  out_code_out;
  logic        out_code_write;
  logic        out_enable_out;
  logic [11:0] out_voltage_out;
  logic [1:0]  out_status;

  conv_result_t expected_results[$];
  int unsigned  mismatches = 0;

  regulator_voltage_code_codec_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_supply       (in_supply),
    .in_voltage_mv   (in_voltage_mv),
    .in_code_in      (in_code_in),
    .in_enable_in    (in_enable_in),
    .out_valid       (out_valid),
    .out_code_out    (out_code_out),
    .out_code_write  (out_code_write),
    .out_enable_out  (out_enable_out),
    .out_voltage_out (out_voltage_out),
    .out_status      (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Segment table of each supply
  function automatic supply_segs_t supply_segs(input int unsigned idx);
    supply_segs_t r;
    case (idx)
      0:       r = '{'h1f, 1500, 3400, 100, 0, 0, 0, 0, 0, 0};
      1:       r = '{'h7f, 500, 1200, 10, 1220, 1540, 20, 0, 0, 0};
      2:       r = '{'h7f, 500, 1200, 10, 1220, 1540, 20, 1600, 3400, 100};
      3:       r = '{'h7f, 500, 1200, 10, 1220, 1840, 20, 0, 0, 0};
      4:       r = '{'h3f, 1400, 3700, 100, 0, 0, 0, 0, 0, 0};
      11:      r = '{'h3f, 500, 3400, 100, 0, 0, 0, 0, 0, 0};
      12:      r = '{'h3f, 500, 1400, 560, 0, 0, 0, 0, 0, 0};
      13:      r = '{'h3f, 500, 1400, 50, 0, 0, 0, 0, 0, 0};
      default: r = '{'h3f, 500, 3500, 100, 0, 0, 0, 0, 0, 0};
    endcase
    return r;
  endfunction

  // Work out the result of one command
  function automatic conv_result_t convert_item(input logic cmd, input logic [3:0] sup,
                                                input logic [11:0] mv, input logic [6:0] code,
                                                input logic en);
    supply_segs_t r;
    conv_result_t res;
    int unsigned  n1, n2, sel, c, c2, val;
    res = '0;
    res.status = ST_OK;
    if (sup >= NUM_SUPPLIES) begin
      res.status = ST_RANGE;
      return res;
    end
    r  = supply_segs(sup);
    n1 = (r.max1 - r.min1) / r.step1;
    if (cmd == CMD_ENCODE) begin
      // zero only disables the supply
      if (mv == 0) return res;
      if (mv >= r.min1 && mv <= r.max1) begin
        sel = (mv - r.min1) / r.step1;
      end else if (r.step2 != 0 && mv >= r.min2 && mv <= r.max2) begin
        sel = n1 + (mv - r.min2) / r.step2 + 1;
      end else if (r.step2 != 0 && r.step3 != 0 && mv >= r.min3 && mv <= r.max3) begin
        n2  = (r.max2 - r.min2) / r.step2;
        sel = n1 + n2 + (mv - r.min3) / r.step3 + 2;
      end else begin
        res.status = ST_RANGE;
        return res;
      end
      res.code   = 7'(sel & r.mask);
      res.write  = 1'b1;
      res.enable = 1'b1;
      return res;
    end
    if (!en) begin
      res.status = ST_DISABLED;
      return res;
    end
    c = code & r.mask;
    if (c <= n1) begin
      val = r.min1 + c * r.step1;
    end else begin
      c2 = c - n1;
      if (r.step2 == 0) begin
        res.status = ST_RANGE;
        return res;
      end
      n2 = (r.max2 - r.min2) / r.step2;
      if (c2 > n2 + 1) begin
        // third segment, or past the last one
        if (r.step3 == 0) begin
          res.status = ST_RANGE;
          return res;
        end
        val = r.min3 + (c2 - n2 - 2) * r.step3;
        if (val > r.max3) begin
          res.status = ST_RANGE;
          return res;
        end
      end else begin
        val = r.min2 + (c2 - 1) * r.step2;
      end
    end
    res.voltage = 12'(val);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("beat with nothing expected", out_status, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_code_out !== want.code) report_mismatch("code_out", out_code_out, want.code);
        if (out_code_write !== want.write)
          report_mismatch("code_write", out_code_write, want.write);
        if (out_enable_out !== want.enable)
          report_mismatch("enable_out", out_enable_out, want.enable);
        if (out_voltage_out !== want.voltage)
          report_mismatch("voltage_out", out_voltage_out, want.voltage);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
  end

  // Present one command and hold it until taken
  task automatic send_item(input logic cmd, input logic [3:0] sup, input logic [11:0] mv,
                           input logic [6:0] code, input logic en);
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_supply     <= sup;
    in_voltage_mv <= mv;
    in_code_in    <= code;
    in_enable_in  <= en;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_results.push_back(convert_item(cmd, sup, mv, code, en));
  endtask

  // Drop start for a burst, with junk on the data ports
  task automatic idle_burst(input int unsigned cycles);
    start         <= 1'b0;
    in_cmd        <= 1'($urandom);
    in_supply     <= 4'($urandom);
    in_voltage_mv <= 12'($urandom);
    in_code_in    <= 7'($urandom);
    in_enable_in  <= 1'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [3:0]  sup;
    logic [11:0] mv;
    logic [6:0]  code;
    sup = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 13));
    case ($urandom_range(0, 7))
      0:       mv = '0;
      1, 2:    mv = 12'($urandom);
      default: mv = 12'($urandom_range(450, 3750));
    endcase
    code = $urandom_range(0, 1) ? 7'($urandom) : 7'($urandom_range(0, 40));
    send_item(1'($urandom), sup, mv, code, $urandom_range(0, 9) != 0);
  endtask

  // Segment edges, gaps, rounding and disable on encode
  task automatic test_encode_edges();
    send_item(CMD_ENCODE, 4'd1, 12'd0, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd1, 12'd500, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd1, 12'd1200, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd1, 12'd1210, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd1, 12'd1540, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd2, 12'd1600, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd2, 12'd3400, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd4, 12'd4095, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd5, 12'd499, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd12, 12'd1400, 7'd0, 1'b1);
    send_item(CMD_ENCODE, 4'd12, 12'd1059, 7'd0, 1'b1);
  endtask

  // Disabled supply, masking, segment boundaries and codes past the table
  task automatic test_decode_edges();
    send_item(CMD_DECODE, 4'd3, 12'd0, 7'd127, 1'b0);
    send_item(CMD_DECODE, 4'd0, 12'd0, 7'd0, 1'b1);
    send_item(CMD_DECODE, 4'd0, 12'd0, 7'd19, 1'b1);
    send_item(CMD_DECODE, 4'd0, 12'd0, 7'd31, 1'b1);
    send_item(CMD_DECODE, 4'd2, 12'd0, 7'd127, 1'b1);
    send_item(CMD_DECODE, 4'd2, 12'd0, 7'd87, 1'b1);
    send_item(CMD_DECODE, 4'd2, 12'd0, 7'd88, 1'b1);
    send_item(CMD_DECODE, 4'd1, 12'd0, 7'd71, 1'b1);
    send_item(CMD_DECODE, 4'd1, 12'd0, 7'd102, 1'b1);
  endtask

  task automatic test_unknown_supply();
    send_item(CMD_ENCODE, 4'd14, 12'd1500, 7'd0, 1'b1);
    send_item(CMD_DECODE, 4'd15, 12'd0, 7'd10, 1'b1);
    send_item(CMD_DECODE, 4'd15, 12'hfff, 7'h7f, 1'b1);
  endtask

  // Random commands with bursts of idle cycles
  task automatic test_random_traffic(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 11));
      send_random_item();
    end
  endtask

  // Random commands back to back
  task automatic test_streaming(input int unsigned count);
    repeat (count) send_random_item();
  endtask

  initial begin
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_cmd        <= 1'b0;
    in_supply     <= '0;
    in_voltage_mv <= '0;
    in_code_in    <= '0;
    in_enable_in  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_encode_edges();
    test_decode_edges();
    test_unknown_supply();
    test_random_traffic(680);
    test_streaming(120);
    // drain the pipeline
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
